// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the hpse_chk checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define HPSE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define HPSE_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hpse_pkg.sv =====
// ---------------------------------------------------------------------------
// hpse_pkg
// Types and constants shared by the heightmap smoothing controller and
// datapath.
// ---------------------------------------------------------------------------
package hpse_pkg;

    localparam int HEIGHT_W = 16;
    localparam int OP_W     = 2;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 11;
    localparam int VAL_W    = 17;
    localparam int RAD_W    = 4;

    // internal coordinate widths, wide enough for center +/- radius +/- 1
    localparam int PC_W     = 12;
    localparam int PR_W     = 13;

    // neighborhood accumulation and divide-by-count via reciprocal
    localparam int SUM_W       = 20;
    localparam int RECIP_W     = 23;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_4 = 23'd4194304;  // 2^24 / 4
    localparam logic [RECIP_W-1:0] RECIP_6 = 23'd2796203;  // ceil(2^24 / 6)
    localparam logic [RECIP_W-1:0] RECIP_9 = 23'd1864136;  // ceil(2^24 / 9)

    localparam logic [3:0] CNT_4   = 4'd4;
    localparam logic [3:0] CNT_6   = 4'd6;
    localparam logic [3:0] NB_LAST = 4'd8;

    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RST = 16'd45696;  // 357.0

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_ADD    = 2'd2,
        OP_SMOOTH = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RDW,
        ST_PCELL,
        ST_NBR,
        ST_DRAIN,
        ST_MUL,
        ST_PWR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;        // capture input beat
        logic set_fail;    // flag out-of-grid center
        logic op0_wr;      // write cell
        logic op1_cap;     // capture read data as result
        logic op2_upd;     // clamped add, write back
        logic patch_init;  // set patch walk to first position
        logic pos_next;    // advance patch position
        logic nb_clear;    // clear neighborhood sum/count
        logic nb_step;     // issue next neighbor read
        logic mul;         // sum times reciprocal
        logic pos_wr;      // write smoothed cell
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic center_ok;
        logic pos_ok;
        logic pos_last;
        logic nb_last;
    } t_dp_sts;

    // 3x3 neighbor offsets in raster order
    function automatic logic signed [1:0] nb_di(input logic [3:0] nb);
        logic signed [1:0] d;
        case (nb) inside
            4'd0, 4'd3, 4'd6: d = -2'sd1;
            4'd1, 4'd4, 4'd7: d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nb_dj(input logic [3:0] nb);
        logic signed [1:0] d;
        case (nb) inside
            [4'd0:4'd2]: d = -2'sd1;
            [4'd3:4'd5]: d = 2'sd0;
            default:     d = 2'sd1;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/hpse_ctrl.sv =====
// ---------------------------------------------------------------------------
// hpse_ctrl
// Sequencer for cell ops and the raster walk of the smoothing patch.
// ---------------------------------------------------------------------------
module hpse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hpse_pkg::t_dp_sts i_sts,
    output logic              o_busy,
    output logic              o_valid,
    output hpse_pkg::t_dp_cmd o_cmd
);
    import hpse_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.center_ok) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = ST_RESP;
                end else begin
                    case (i_sts.op)
                        OP_WRITE: begin
                            o_cmd.op0_wr = 1'b1;
                            n_state      = ST_RESP;
                        end
                        OP_READ, OP_ADD: begin
                            // center address is on the read port this cycle
                            n_state = ST_RDW;
                        end
                        OP_SMOOTH: begin
                            o_cmd.patch_init = 1'b1;
                            n_state          = ST_PCELL;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RDW: begin
                if (i_sts.op == OP_READ) begin
                    o_cmd.op1_cap = 1'b1;
                end else begin
                    o_cmd.op2_upd = 1'b1;
                end
                n_state = ST_RESP;
            end
            ST_PCELL: begin
                if (i_sts.pos_ok) begin
                    o_cmd.nb_clear = 1'b1;
                    n_state        = ST_NBR;
                end else if (i_sts.pos_last) begin
                    n_state = ST_RESP;
                end else begin
                    o_cmd.pos_next = 1'b1;
                end
            end
            ST_NBR: begin
                o_cmd.nb_step = 1'b1;
                if (i_sts.nb_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_PWR;
            end
            ST_PWR: begin
                o_cmd.pos_wr = 1'b1;
                if (i_sts.pos_last) begin
                    n_state = ST_RESP;
                end else begin
                    o_cmd.pos_next = 1'b1;
                    n_state        = ST_PCELL;
                end
            end
            ST_RESP: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/hpse_dp.sv =====
// ---------------------------------------------------------------------------
// hpse_dp
// Height store, address generation, clamp and 3x3 mean datapath.
// ---------------------------------------------------------------------------
module hpse_dp #(
    parameter int GRID_COLS  = 128,
    parameter int GRID_ROWS  = 512,
    parameter int MAX_RADIUS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [hpse_pkg::OP_W-1:0]           i_op,
    input  logic signed [hpse_pkg::COL_W-1:0]   i_col,
    input  logic signed [hpse_pkg::ROW_W-1:0]   i_row,
    input  logic signed [hpse_pkg::VAL_W-1:0]   i_value,
    input  logic [hpse_pkg::RAD_W-1:0]          i_radius,
    input  logic                                i_cfg_we,
    input  logic [hpse_pkg::HEIGHT_W-1:0]       i_cfg_data,
    input  hpse_pkg::t_dp_cmd                   i_cmd,
    output hpse_pkg::t_dp_sts                   o_sts,
    output logic [hpse_pkg::HEIGHT_W-1:0]       o_height_out,
    output logic                                o_status
);
    import hpse_pkg::*;

    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = $clog2(GRID_COLS);
    localparam int RIW   = $clog2(GRID_ROWS);
    localparam logic signed [PC_W-1:0] COLS_S = PC_W'(GRID_COLS);
    localparam logic signed [PR_W-1:0] ROWS_S = PR_W'(GRID_ROWS);

    function automatic logic in_grid(input logic signed [PC_W-1:0] c,
                                     input logic signed [PR_W-1:0] r);
        return (c >= 0) && (c < COLS_S) && (r >= 0) && (r < ROWS_S);
    endfunction

    logic [HEIGHT_W-1:0]        r_max_h;
    t_op                        r_op;
    logic signed [PC_W-1:0]     r_col;
    logic signed [PR_W-1:0]     r_row;
    logic signed [VAL_W-1:0]    r_val;
    logic [RAD_W-1:0]           r_rad;
    logic signed [PC_W-1:0]     r_pi;
    logic signed [PC_W-1:0]     r_pi0;
    logic signed [PC_W-1:0]     r_pi_end;
    logic signed [PR_W-1:0]     r_pj;
    logic signed [PR_W-1:0]     r_pj_end;
    logic [3:0]                 r_nb;
    logic                       r_rd_vld;
    logic [SUM_W-1:0]           r_sum;
    logic [3:0]                 r_cnt;
    logic [PROD_W-1:0]          r_prod;
    logic [HEIGHT_W-1:0]        r_rd_data;
    logic [HEIGHT_W-1:0]        r_res_h;
    logic                       r_res_st;
    logic [HEIGHT_W-1:0]        r_mem [DEPTH];

    logic [RAD_W-1:0]           w_rad_sat;
    logic signed [PC_W-1:0]     w_nc;
    logic signed [PR_W-1:0]     w_nr;
    logic signed [PC_W-1:0]     w_sc;
    logic signed [PR_W-1:0]     w_sr;
    logic [AW-1:0]              w_addr;
    logic                       w_we;
    logic [HEIGHT_W-1:0]        w_wdata;
    logic [HEIGHT_W-1:0]        w_wr0;
    logic signed [HEIGHT_W+1:0] w_add;
    logic [HEIGHT_W-1:0]        w_add_clamp;
    logic [RECIP_W-1:0]         w_recip;
    logic [HEIGHT_W-1:0]        w_quo;

    assign w_rad_sat = (int'(i_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : i_radius;

    assign w_nc = r_pi + PC_W'(nb_di(r_nb));
    assign w_nr = r_pj + PR_W'(nb_dj(r_nb));

    // one address generator: patch write, neighbor read, else the center
    always_comb begin
        if (i_cmd.pos_wr) begin
            w_sc = r_pi;
            w_sr = r_pj;
        end else if (i_cmd.nb_step) begin
            w_sc = w_nc;
            w_sr = w_nr;
        end else begin
            w_sc = r_col;
            w_sr = r_row;
        end
    end

    assign w_addr = AW'(AW'(w_sr[RIW-1:0]) * AW'(GRID_COLS)) + AW'(w_sc[CIW-1:0]);

    // op 0: negative saturates to zero, positive fits in 16 bits
    assign w_wr0 = r_val[VAL_W-1] ? '0 : r_val[HEIGHT_W-1:0];

    // op 2: 18-bit signed sum, clamp to 0..max_height
    assign w_add = $signed({2'b00, r_rd_data}) + $signed({r_val[VAL_W-1], r_val});

    always_comb begin
        if (w_add[HEIGHT_W+1]) begin
            w_add_clamp = '0;
        end else if (w_add[HEIGHT_W:0] > {1'b0, r_max_h}) begin
            w_add_clamp = r_max_h;
        end else begin
            w_add_clamp = w_add[HEIGHT_W-1:0];
        end
    end

    always_comb begin
        case (r_cnt)
            CNT_4:   w_recip = RECIP_4;
            CNT_6:   w_recip = RECIP_6;
            default: w_recip = RECIP_9;
        endcase
    end

    assign w_quo = r_prod[RECIP_SHIFT +: HEIGHT_W];

    always_comb begin
        if (i_cmd.op0_wr) begin
            w_wdata = w_wr0;
        end else if (i_cmd.op2_upd) begin
            w_wdata = w_add_clamp;
        end else begin
            w_wdata = w_quo;
        end
    end

    assign w_we = i_cmd.op0_wr | i_cmd.op2_upd | i_cmd.pos_wr;

    // height store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_h  <= MAX_HEIGHT_RST;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_h <= i_cfg_data;
            end
            r_rd_vld <= i_cmd.nb_step && in_grid(w_nc, w_nr);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_col    <= PC_W'(i_col);
            r_row    <= PR_W'(i_row);
            r_val    <= i_value;
            r_rad    <= w_rad_sat;
            r_res_h  <= '0;
            r_res_st <= 1'b0;
        end
        if (i_cmd.set_fail) begin
            r_res_st <= 1'b1;
        end
        if (i_cmd.op0_wr) begin
            r_res_h <= w_wr0;
        end
        if (i_cmd.op1_cap) begin
            r_res_h <= r_rd_data;
        end
        if (i_cmd.op2_upd) begin
            r_res_h <= w_add_clamp;
        end

        if (i_cmd.patch_init) begin
            r_pi     <= r_col - PC_W'(r_rad);
            r_pi0    <= r_col - PC_W'(r_rad);
            r_pi_end <= r_col + PC_W'(r_rad);
            r_pj     <= r_row - PR_W'(r_rad);
            r_pj_end <= r_row + PR_W'(r_rad);
        end else if (i_cmd.pos_next) begin
            if (r_pi == r_pi_end) begin
                r_pi <= r_pi0;
                r_pj <= r_pj + PR_W'(1);
            end else begin
                r_pi <= r_pi + PC_W'(1);
            end
        end

        if (i_cmd.nb_clear) begin
            r_nb  <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.nb_step) begin
                r_nb <= r_nb + 4'd1;
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + SUM_W'(r_rd_data);
                r_cnt <= r_cnt + 4'd1;
            end
        end

        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(w_recip);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.center_ok = in_grid(r_col, r_row);
    assign o_sts.pos_ok    = in_grid(r_pi, r_pj);
    assign o_sts.pos_last  = (r_pi == r_pi_end) && (r_pj == r_pj_end);
    assign o_sts.nb_last   = (r_nb == NB_LAST);

    assign o_height_out = r_res_h;
    assign o_status     = r_res_st;

endmodule

// ===== sv/heightmap_patch_smoothing_engine.sv =====
// ---------------------------------------------------------------------------
// heightmap_patch_smoothing_engine
// Start beat to o_valid: write or out-of-grid goes CHECK then RESP; read/add goes CHECK, RDW, RESP;
// smooth walks the patch positions in raster order (PCELL, then NBR, DRAIN, MUL, PWR, 9 reads/cell).
// One beat at a time; start is taken when busy is low, i.e. in the cycle after o_valid.
// Sync active-low reset: idle, max_height = 45696; height store is not cleared.
// ---------------------------------------------------------------------------
module heightmap_patch_smoothing_engine #(
    parameter int GRID_COLS  = 128,
    parameter int GRID_ROWS  = 512,
    parameter int MAX_RADIUS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command beat
    input  logic                                start,
    output logic                                busy,
    input  logic [hpse_pkg::OP_W-1:0]           i_op,
    input  logic signed [hpse_pkg::COL_W-1:0]   i_col,
    input  logic signed [hpse_pkg::ROW_W-1:0]   i_row,
    input  logic signed [hpse_pkg::VAL_W-1:0]   i_value,
    input  logic [hpse_pkg::RAD_W-1:0]          i_radius,
    // max_height register
    input  logic                                i_cfg_we,
    input  logic [hpse_pkg::HEIGHT_W-1:0]       i_cfg_data,
    // result beat, one cycle, cannot be held off
    output logic                                o_valid,
    output logic [hpse_pkg::HEIGHT_W-1:0]       o_height_out,
    output logic                                o_status
);
    import hpse_pkg::*;

    // The controller sequences every op. The datapath owns the height store
    // (one write port, one registered read port), so the smoothing pass
    // reads the nine neighbors of a cell one per cycle: the read of
    // neighbor k overlaps the accumulate of neighbor k-1. After the last
    // read drains, the sum is multiplied by a reciprocal of the in-grid
    // count (4, 6 or 9) and the truncated mean is written back in place,
    // so later cells of the raster walk see already-smoothed values.
    //
    // Out-of-grid patch positions are skipped.
    // An out-of-grid center aborts the op with status 1, height 0.

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    hpse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    hpse_dp #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_value      (i_value),
        .i_radius     (i_radius),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_height_out (o_height_out),
        .o_status     (o_status)
    );

endmodule

// ===== sv/hpse_chk.sv =====
// ---------------------------------------------------------------------------
// hpse_chk
// Port-level checks on the command/result beats of the smoothing engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hpse_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [hpse_pkg::HEIGHT_W-1:0] o_height_out,
    input logic                          o_status
);
    import hpse_pkg::*;

    // an accepted beat always occupies the engine on the next cycle
    `HPSE_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept not followed by busy")
    // a result only appears while the engine is occupied
    `HPSE_ASSERT(a_valid_busy, i_clk, i_rst_n, o_valid |-> busy, "result beat while idle")
    // one result beat per item, then back to idle
    `HPSE_ASSERT(a_valid_done, i_clk, i_rst_n, o_valid |=> (!o_valid && !busy), "result not single")
    // a rejected op reports zero height
    `HPSE_ASSERT(a_fail_zero, i_clk, i_rst_n, (o_valid && o_status) |-> (o_height_out == '0), "fail with height")
    // reset leaves the engine idle with no result
    `HPSE_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_valid), "not idle after reset")

endmodule

bind heightmap_patch_smoothing_engine hpse_chk u_hpse_chk (.*);

// ===== verif/tb_heightmap_patch_smoothing_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_patch_smoothing_engine
// Self-checking bench for the heightmap smoothing engine. Commands go in
// through the start/busy handshake. Each command runs against an in-bench
// model of the height grid and the max_height clamp, and every result beat
// is checked in order against the model's answer. Directed edge cases come
// first: value extremes, the clamp, out-of-grid cells, and smoothing at
// corners and edges. Random phases with paced bursts follow, each under a
// new clamp setting.
// ----------------------------------------------------------------------------
module tb_heightmap_patch_smoothing_engine;
    import hpse_pkg::*;

    localparam int GRID_COLS     = 128;
    localparam int GRID_ROWS     = 512;
    localparam int MAX_RADIUS    = 15;
    localparam int RANDOM_ITEMS  = 750;
    localparam int RANDOM_PHASES = 6;
    localparam int ZONES         = 9;

    // one command beat, fields at port widths
    typedef struct {
        t_op                       op;
        logic signed [COL_W-1:0]   col;
        logic signed [ROW_W-1:0]   row;
        logic signed [VAL_W-1:0]   value;
        logic [RAD_W-1:0]          radius;
    } t_command;

    // what the engine should answer for one command
    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic                status;
    } t_answer;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        start       = 1'b0;
    logic                        busy;
    logic [OP_W-1:0]             i_op        = '0;
    logic signed [COL_W-1:0]     i_col       = '0;
    logic signed [ROW_W-1:0]     i_row       = '0;
    logic signed [VAL_W-1:0]     i_value     = '0;
    logic [RAD_W-1:0]            i_radius    = '0;
    logic                        i_cfg_we    = 1'b0;
    logic [HEIGHT_W-1:0]         i_cfg_data  = '0;
    logic                        o_valid;
    logic [HEIGHT_W-1:0]         o_height_out;
    logic                        o_status;

    // model of the grid; the bench tracks which cells hold a written value so
    // that no command ever reads a cell the engine was never given
    logic [HEIGHT_W-1:0] height_grid  [0:GRID_COLS*GRID_ROWS-1];
    bit                  cell_written [0:GRID_COLS*GRID_ROWS-1];
    logic [HEIGHT_W-1:0] max_height_now = MAX_HEIGHT_RST;

    t_answer pending_answers[$];
    int      error_count   = 0;
    int      commands_sent = 0;
    int      burst_left    = 4;

    // anchors for in-grid traffic: the four corners (large patches allowed
    // there), edge middles, and interior spots on both sides of row 256
    int zone_col [ZONES] = '{0, 127, 0, 127, 64, 0, 127, 64, 40};
    int zone_row [ZONES] = '{0, 0, 511, 511, 0, 256, 300, 400, 100};

    heightmap_patch_smoothing_engine #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_value      (i_value),
        .i_radius     (i_radius),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_height_out (o_height_out),
        .o_status     (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------------
    function automatic bit on_grid(int c, int r);
        return c >= 0 && c < GRID_COLS && r >= 0 && r < GRID_ROWS;
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Raster walk over the patch; each in-grid cell takes the truncated mean
    // of its in-grid 3x3 neighborhood. Cells already done this pass feed the
    // later ones, exactly as the hardware walks them.
    function automatic void smooth_patch_in_place(int cx, int cy, int rad);
        int i, j, di, dj, sum_v, cnt;
        for (j = cy - rad; j <= cy + rad; j++) begin
            for (i = cx - rad; i <= cx + rad; i++) begin
                if (on_grid(i, j)) begin
                    sum_v = 0;
                    cnt   = 0;
                    for (dj = -1; dj <= 1; dj++) begin
                        for (di = -1; di <= 1; di++) begin
                            if (on_grid(i + di, j + dj)) begin
                                sum_v += height_grid[(j + dj) * GRID_COLS + i + di];
                                cnt++;
                            end
                        end
                    end
                    height_grid[j * GRID_COLS + i] = HEIGHT_W'(sum_v / cnt);
                end
            end
        end
    endfunction

    // Applies one accepted command to the model and returns the answer due.
    function automatic t_answer predict_answer(t_command cmd);
        t_answer ans;
        int      col_i, row_i, idx, sum_v, rad;
        ans.height = '0;
        ans.status = 1'b0;
        col_i      = cmd.col;
        row_i      = cmd.row;
        if (!on_grid(col_i, row_i)) begin
            ans.status = 1'b1;
        end else begin
            idx = row_i * GRID_COLS + col_i;
            case (cmd.op)
                OP_WRITE: begin
                    // negative saturates to 0; no upper clamp on a plain write
                    ans.height = (cmd.value < 0) ? '0 : cmd.value[HEIGHT_W-1:0];
                    height_grid[idx]  = ans.height;
                    cell_written[idx] = 1'b1;
                end
                OP_READ: begin
                    ans.height = height_grid[idx];
                end
                OP_ADD: begin
                    sum_v = int'(height_grid[idx]) + int'(cmd.value);
                    if (sum_v > int'(max_height_now))
                        sum_v = int'(max_height_now);
                    else if (sum_v < 0)
                        sum_v = 0;
                    ans.height = HEIGHT_W'(sum_v);
                    height_grid[idx] = ans.height;
                end
                default: begin
                    rad = cmd.radius;
                    if (rad > MAX_RADIUS)
                        rad = MAX_RADIUS;
                    smooth_patch_in_place(col_i, row_i, rad);
                end
            endcase
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Command building
    // ------------------------------------------------------------------------
    function automatic t_command make_cmd(t_op op, int col, int row, int value, int radius);
        t_command cmd;
        cmd.op     = op;
        cmd.col    = col[COL_W-1:0];
        cmd.row    = row[ROW_W-1:0];
        cmd.value  = value[VAL_W-1:0];
        cmd.radius = radius[RAD_W-1:0];
        return cmd;
    endfunction

    // height for a write: mostly in range, some negatives that must saturate
    function automatic int pick_height();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2)
            return -int'($urandom_range(1, 65536));
        else if (roll == 2)
            return 65535;
        else if (roll == 3)
            return 0;
        return $urandom_range(0, 65535);
    endfunction

    // delta for an add: full signed range now and then, else modest steps
    function automatic int pick_delta();
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 131071)) - 65536;
        return int'($urandom_range(0, 4000)) - 2000;
    endfunction

    // any op at a coordinate outside the grid; nothing may change
    function automatic t_command random_offgrid_command();
        int col_v, row_v;
        col_v = $urandom_range(0, GRID_COLS - 1);
        row_v = $urandom_range(0, GRID_ROWS - 1);
        case ($urandom_range(0, 5))
            0: col_v = -1;
            1: col_v = GRID_COLS;
            2: row_v = -1;
            3: row_v = GRID_ROWS;
            default: begin
                do begin
                    col_v = int'($urandom_range(0, 1023)) - 512;
                    row_v = int'($urandom_range(0, 2047)) - 1024;
                end while (on_grid(col_v, row_v));
            end
        endcase
        return make_cmd(t_op'($urandom_range(0, 3)), col_v, row_v, int'($urandom()),
                        $urandom_range(0, 15));
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Random burst pacing. start is left high after a beat when the next one
    // follows at once; it drops here, in a time step of its own, or in wait_drained.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // Drive one beat and hold it until the engine takes it (start & !busy).
    task automatic send_command(input t_command cmd);
        i_op     <= cmd.op;
        i_col    <= cmd.col;
        i_row    <= cmd.row;
        i_value  <= cmd.value;
        i_radius <= cmd.radius;
        start    <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_answers.push_back(predict_answer(cmd));
        commands_sent++;
        pace_sender();
    endtask

    // Stop sending until every answer has come back. Always waits for a clock
    // edge so start never falls and rises in the same step.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    // Register write, only with the engine idle.
    task automatic set_max_height(input logic [HEIGHT_W-1:0] limit);
        wait_drained();
        while (busy) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        max_height_now = limit;
    endtask

    // Write every in-grid cell of the box that has no value yet, so that a
    // following read, add or smooth only touches defined heights.
    task automatic prepare_window(int c_lo, int c_hi, int r_lo, int r_hi);
        int c, r;
        for (r = clamp_int(r_lo, 0, GRID_ROWS - 1); r <= clamp_int(r_hi, 0, GRID_ROWS - 1);
             r++) begin
            for (c = clamp_int(c_lo, 0, GRID_COLS - 1);
                 c <= clamp_int(c_hi, 0, GRID_COLS - 1); c++) begin
                if (!cell_written[r * GRID_COLS + c])
                    send_command(make_cmd(OP_WRITE, c, r, pick_height(),
                                          $urandom_range(0, 15)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking: one beat per valid cycle, in order, no back-pressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result beat: height_out %0d status %0d",
                       o_height_out, o_status);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_height_out !== want.height) begin
                    $error("height_out: expected %0d, actual %0d", want.height, o_height_out);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Writes at the value extremes and read-back, with the clamp at reset.
    task automatic test_write_read_extremes();
        send_command(make_cmd(OP_WRITE, 0, 0, 65535, 0));        // above clamp, kept
        send_command(make_cmd(OP_READ, 0, 0, 0, 15));
        send_command(make_cmd(OP_WRITE, 127, 511, -65536, 0));   // most negative -> 0
        send_command(make_cmd(OP_WRITE, 127, 511, -1, 0));
        send_command(make_cmd(OP_READ, 127, 511, -1, 0));
        send_command(make_cmd(OP_WRITE, 5, 257, 1, 0));
        send_command(make_cmd(OP_READ, 5, 257, 0, 0));
    endtask

    // Add at and past both clamp limits, reset value of max_height.
    task automatic test_add_clamp();
        send_command(make_cmd(OP_WRITE, 10, 10, 45000, 0));
        send_command(make_cmd(OP_ADD, 10, 10, 1000, 0));         // stops at 45696
        send_command(make_cmd(OP_ADD, 10, 10, -65536, 0));       // floors at 0
        send_command(make_cmd(OP_ADD, 10, 10, 65535, 0));
        send_command(make_cmd(OP_ADD, 10, 10, -1, 0));
        send_command(make_cmd(OP_READ, 10, 10, 0, 0));
    endtask

    // Each op just outside one grid edge, and ops at the field extremes.
    task automatic test_out_of_grid();
        send_command(make_cmd(OP_WRITE, -1, 0, 100, 0));
        send_command(make_cmd(OP_READ, GRID_COLS, 0, 0, 0));
        send_command(make_cmd(OP_ADD, 0, -1, 5, 0));
        send_command(make_cmd(OP_SMOOTH, 0, GRID_ROWS, 0, 15));
        send_command(make_cmd(OP_WRITE, -512, -1024, -65536, 15));
        send_command(make_cmd(OP_SMOOTH, 511, 1023, 65535, 3));
        send_command(make_cmd(OP_READ, 0, 0, 0, 0));            // corner untouched
    endtask

    // Smoothing with 4-, 6- and 9-cell neighborhoods and patches that hang
    // over the grid edge.
    task automatic test_smooth_patches();
        prepare_window(0, 2, 0, 2);
        send_command(make_cmd(OP_SMOOTH, 0, 0, 0, 1));
        send_command(make_cmd(OP_READ, 1, 1, 0, 0));
        prepare_window(63, 65, 0, 1);
        send_command(make_cmd(OP_SMOOTH, 64, 0, 0, 0));
        send_command(make_cmd(OP_READ, 64, 0, 0, 0));
        prepare_window(38, 42, 98, 102);
        send_command(make_cmd(OP_SMOOTH, 40, 100, 0, 1));
        send_command(make_cmd(OP_READ, 40, 100, 0, 0));
        prepare_window(124, 127, 508, 511);
        send_command(make_cmd(OP_SMOOTH, 127, 511, 0, 2));
        send_command(make_cmd(OP_READ, 126, 510, 0, 0));
        prepare_window(0, 1, 255, 257);
        send_command(make_cmd(OP_SMOOTH, 0, 256, 0, 0));
    endtask

    // Clamp register at its extremes and at one.
    task automatic test_config_extremes();
        set_max_height(16'd0);
        send_command(make_cmd(OP_WRITE, 20, 20, 1000, 0));
        send_command(make_cmd(OP_ADD, 20, 20, 5, 0));           // everything clamps to 0
        set_max_height(16'hFFFF);
        send_command(make_cmd(OP_WRITE, 20, 20, 65535, 0));
        send_command(make_cmd(OP_ADD, 20, 20, 65535, 0));
        send_command(make_cmd(OP_ADD, 20, 20, -65536, 0));
        set_max_height(16'd1);
        send_command(make_cmd(OP_ADD, 20, 20, 100, 0));
    endtask

    // Random traffic in phases, each under its own clamp. Most commands land
    // near the anchor zones, where earlier writes make reads and patches
    // legal; the rest are off-grid noise.
    task automatic test_random_mix();
        int phase, stop_at, roll, zone, col_c, row_c, rad;
        logic [HEIGHT_W-1:0] limit;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1:       limit = 16'hFFFF;
                3:       limit = HEIGHT_W'($urandom_range(0, 200));
                5:       limit = MAX_HEIGHT_RST;
                default: limit = HEIGHT_W'($urandom_range(0, 65535));
            endcase
            set_max_height(limit);
            stop_at = commands_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (commands_sent < stop_at) begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    send_command(random_offgrid_command());
                end else begin
                    zone  = $urandom_range(0, ZONES - 1);
                    col_c = clamp_int(zone_col[zone] + int'($urandom_range(0, 12)) - 6,
                                      0, GRID_COLS - 1);
                    row_c = clamp_int(zone_row[zone] + int'($urandom_range(0, 12)) - 6,
                                      0, GRID_ROWS - 1);
                    roll  = $urandom_range(0, 99);
                    if (roll < 25) begin
                        send_command(make_cmd(OP_WRITE, col_c, row_c, pick_height(),
                                              $urandom_range(0, 15)));
                    end else if (roll < 50) begin
                        prepare_window(col_c, col_c, row_c, row_c);
                        send_command(make_cmd(OP_READ, col_c, row_c, int'($urandom()),
                                              $urandom_range(0, 15)));
                    end else if (roll < 78) begin
                        prepare_window(col_c, col_c, row_c, row_c);
                        send_command(make_cmd(OP_ADD, col_c, row_c, pick_delta(),
                                              $urandom_range(0, 15)));
                    end else begin
                        // big patches only at the corners, where most of the
                        // patch falls off the grid and the fill stays cheap
                        roll = $urandom_range(0, 99);
                        if (zone < 4 && roll >= 90)
                            rad = $urandom_range(7, 15);
                        else if (roll >= 60)
                            rad = $urandom_range(3, 6);
                        else
                            rad = $urandom_range(0, 2);
                        prepare_window(col_c - rad - 1, col_c + rad + 1,
                                       row_c - rad - 1, row_c + rad + 1);
                        send_command(make_cmd(OP_SMOOTH, col_c, row_c, int'($urandom()), rad));
                    end
                end
                // now and then hold off until the engine has answered everything
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_write_read_extremes();
        test_add_clamp();
        test_out_of_grid();
        test_smooth_patches();
        test_config_extremes();
        test_random_mix();
        wait_drained();
        // any late or extra beat shows up as unexpected here
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run of this stimulus.
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
